[hdl/vpw_pulse_frame_receiver_top_assert.svh]
// Assertion shorthands used by the receiver frame module.
// Both expect clk and arst_n in scope.
`ifndef VPW_PULSE_FRAME_RECEIVER_TOP_ASSERT_SVH
`define VPW_PULSE_FRAME_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication
`define VPWR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VPWR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/vpwr_pkg.sv]
package vpwr_pkg;

	localparam int unsigned FRAME_BYTES  = 12;
	// CRC is forced to zero when more bytes than this precede the last one
	localparam int unsigned CRC_SPAN_MAX = 11;
	localparam logic [7:0]  CRC_POLY     = 8'h1D;
	localparam logic [7:0]  CRC_INIT     = 8'hFF;

	localparam logic [15:0] SOF_MIN_RST   = 16'd163;
	localparam logic [15:0] SOF_MAX_RST   = 16'd239;
	localparam logic [15:0] LONG_MIN_RST  = 16'd96;
	localparam logic [15:0] LONG_MAX_RST  = 16'd163;
	localparam logic [15:0] SHORT_MIN_RST = 16'd34;
	localparam logic [15:0] SHORT_MAX_RST = 16'd96;
	localparam logic [15:0] END_MIN_RST   = 16'd163;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_EOF   = 2'd1,
		KIND_ABORT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_SOF_MIN   = 3'd0,
		REG_SOF_MAX   = 3'd1,
		REG_LONG_MIN  = 3'd2,
		REG_LONG_MAX  = 3'd3,
		REG_SHORT_MIN = 3'd4,
		REG_SHORT_MAX = 3'd5,
		REG_END_MIN   = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic [15:0] sof_min;
		logic [15:0] sof_max;
		logic [15:0] long_min;
		logic [15:0] long_max;
		logic [15:0] short_min;
		logic [15:0] short_max;
		logic [15:0] end_min;
	} thr_t;

	typedef struct packed {
		logic sof;
		logic frame_end;
		logic bit_ok;
		logic bit_val;
	} pulse_cls_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_value;
		logic [3:0]  byte_index;
		logic [4:0]  frame_length;
		logic        crc_ok;
		logic [31:0] frame_number;
	} result_t;

	// one byte through the CRC-8 register, MSB first
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ data[i];
			c  = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

[hdl/vpwr_cfg.sv]
module vpwr_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_wdata,
	output vpwr_pkg::thr_t   thr
);
	import vpwr_pkg::*;

	thr_t thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.sof_min   <= SOF_MIN_RST;
			thr_q.sof_max   <= SOF_MAX_RST;
			thr_q.long_min  <= LONG_MIN_RST;
			thr_q.long_max  <= LONG_MAX_RST;
			thr_q.short_min <= SHORT_MIN_RST;
			thr_q.short_max <= SHORT_MAX_RST;
			thr_q.end_min   <= END_MIN_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SOF_MIN:   thr_q.sof_min   <= cfg_wdata;
				REG_SOF_MAX:   thr_q.sof_max   <= cfg_wdata;
				REG_LONG_MIN:  thr_q.long_min  <= cfg_wdata;
				REG_LONG_MAX:  thr_q.long_max  <= cfg_wdata;
				REG_SHORT_MIN: thr_q.short_min <= cfg_wdata;
				REG_SHORT_MAX: thr_q.short_max <= cfg_wdata;
				REG_END_MIN:   thr_q.end_min   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign thr = thr_q;

endmodule

[hdl/vpwr_classify.sv]
module vpwr_classify (
	input  logic                 expect_rise,
	input  logic [31:0]          edge_time,
	input  logic [31:0]          rise_time,
	input  logic [31:0]          fall_time,
	input  vpwr_pkg::thr_t       thr,
	output vpwr_pkg::pulse_cls_t cls
);
	import vpwr_pkg::*;

	logic [31:0] width;
	logic        stamp_ok;
	logic        in_sof;
	logic        in_long;
	logic        in_short;

	// rising edge ends a passive pulse, falling edge an active one
	assign width    = expect_rise ? (edge_time - fall_time) : (edge_time - rise_time);
	assign stamp_ok = rise_time <= edge_time;

	assign in_sof   = (width > {16'd0, thr.sof_min})   && (width <= {16'd0, thr.sof_max});
	assign in_long  = (width > {16'd0, thr.long_min})  && (width <= {16'd0, thr.long_max});
	assign in_short = (width > {16'd0, thr.short_min}) && (width <= {16'd0, thr.short_max});

	always_comb begin
		cls.sof       = !expect_rise && stamp_ok && in_sof;
		cls.frame_end = expect_rise && (width > {16'd0, thr.end_min});
		cls.bit_ok    = (expect_rise || stamp_ok) && (in_long || in_short);
		// passive long = 1, active long = 0; short is the opposite
		cls.bit_val   = in_long ? expect_rise : !expect_rise;
	end

endmodule

[hdl/vpwr_frame.sv]
`include "vpw_pulse_frame_receiver_top_assert.svh"

module vpwr_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [31:0]       edge_time,
	input  vpwr_pkg::thr_t    thr,
	output logic              emit,
	output vpwr_pkg::result_t res
);
	import vpwr_pkg::*;

	logic [31:0] rise_time_q, fall_time_q, sof_count_q;
	logic        expect_rise_q, in_frame_q;
	logic [2:0]  bit_index_q;
	logic [4:0]  byte_total_q;
	logic [7:0]  shift_byte_q, prior_byte_q, crc_q;

	logic [31:0] rise_time_d, fall_time_d, sof_count_d;
	logic        expect_rise_d, in_frame_d;
	logic [2:0]  bit_index_d;
	logic [4:0]  byte_total_d;
	logic [7:0]  shift_byte_d, prior_byte_d, crc_d;

	pulse_cls_t  cls;
	logic        do_shift;
	logic [7:0]  next_byte;
	logic [7:0]  crc_ref;

	vpwr_classify u_classify (
		.expect_rise (expect_rise_q),
		.edge_time   (edge_time),
		.rise_time   (rise_time_q),
		.fall_time   (fall_time_q),
		.thr         (thr),
		.cls         (cls)
	);

	assign next_byte = {shift_byte_q[6:0], cls.bit_val};
	assign crc_ref   = (byte_total_q > 5'(CRC_SPAN_MAX + 1)) ? 8'd0 : ~crc_q;

	always_comb begin
		rise_time_d   = rise_time_q;
		fall_time_d   = fall_time_q;
		sof_count_d   = sof_count_q;
		expect_rise_d = !expect_rise_q;
		in_frame_d    = in_frame_q;
		bit_index_d   = bit_index_q;
		byte_total_d  = byte_total_q;
		shift_byte_d  = shift_byte_q;
		prior_byte_d  = prior_byte_q;
		crc_d         = crc_q;
		do_shift      = 1'b0;
		emit          = 1'b0;
		res           = '0;
		res.kind      = KIND_BYTE;
		res.frame_number = sof_count_q;

		if (expect_rise_q) begin
			rise_time_d = edge_time;
			if (in_frame_q) begin
				if (cls.frame_end) begin
					in_frame_d       = 1'b0;
					emit             = 1'b1;
					res.kind         = KIND_EOF;
					res.frame_length = byte_total_q;
					res.crc_ok       = (byte_total_q > 5'd4) && (crc_ref == prior_byte_q);
				end else begin
					do_shift = cls.bit_ok;
				end
			end
		end else begin
			fall_time_d = edge_time;
			if (cls.sof) begin
				sof_count_d  = sof_count_q + 32'd1;
				in_frame_d   = 1'b1;
				bit_index_d  = '0;
				byte_total_d = '0;
				shift_byte_d = '0;
				prior_byte_d = '0;
				crc_d        = CRC_INIT;
			end else begin
				do_shift = in_frame_q && cls.bit_ok;
			end
		end

		if (do_shift) begin
			if (bit_index_q == 3'd7) begin
				if (byte_total_q >= 5'(FRAME_BYTES)) begin
					in_frame_d   = 1'b0;
					bit_index_d  = '0;
					byte_total_d = '0;
					shift_byte_d = '0;
					prior_byte_d = '0;
					crc_d        = CRC_INIT;
					emit         = 1'b1;
					res.kind     = KIND_ABORT;
				end else begin
					emit           = 1'b1;
					res.kind       = KIND_BYTE;
					res.byte_value = next_byte;
					res.byte_index = byte_total_q[3:0];
					if (byte_total_q != '0) begin
						crc_d = crc_fold(crc_q, prior_byte_q);
					end
					prior_byte_d = next_byte;
					byte_total_d = byte_total_q + 5'd1;
					bit_index_d  = '0;
					shift_byte_d = '0;
				end
			end else begin
				shift_byte_d = next_byte;
				bit_index_d  = bit_index_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_time_q   <= '0;
			fall_time_q   <= '0;
			sof_count_q   <= '0;
			expect_rise_q <= 1'b1;
			in_frame_q    <= 1'b0;
			bit_index_q   <= '0;
			byte_total_q  <= '0;
			shift_byte_q  <= '0;
			prior_byte_q  <= '0;
			crc_q         <= CRC_INIT;
		end else if (fire) begin
			rise_time_q   <= rise_time_d;
			fall_time_q   <= fall_time_d;
			sof_count_q   <= sof_count_d;
			expect_rise_q <= expect_rise_d;
			in_frame_q    <= in_frame_d;
			bit_index_q   <= bit_index_d;
			byte_total_q  <= byte_total_d;
			shift_byte_q  <= shift_byte_d;
			prior_byte_q  <= prior_byte_d;
			crc_q         <= crc_d;
		end
	end

	`VPWR_ASSERT_NOW(a_byte_cap, 1'b1, byte_total_q <= 5'(FRAME_BYTES), "byte count past capacity")
	`VPWR_ASSERT_NEXT(a_polarity, fire, expect_rise_q != $past(expect_rise_q), "edge polarity stuck")
	`VPWR_ASSERT_NEXT(a_close, fire && emit && (res.kind == KIND_EOF || res.kind == KIND_ABORT), !in_frame_q, "frame still open after end or abort")
	`VPWR_ASSERT_NEXT(a_sof_clear, fire && cls.sof, in_frame_q && (byte_total_q == '0) && (bit_index_q == '0), "start of frame left stale state")

endmodule

[hdl/vpw_pulse_frame_receiver_top.sv]
// J1850 VPW pulse receiver: each input beat is one bus edge timestamp (edges alternate,
// rising first after reset); the block classifies pulse widths and returns a beat per
// completed byte, per end of frame (length and CRC-8 check) and per overflow abort.
// One beat is taken every clock unless the result register is full and m_tready is
// low; the edge is held in the input register, the frame state is updated from it
// and a result is held in the result register. m_tready feeds s_tready
// combinationally. Write the thresholds only while no beat is in flight.
module vpw_pulse_frame_receiver_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] edge_time
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [7:0] byte_value, [11:8] byte_index,
	                               // [16:12] frame_length, [17] crc_ok,
	                               // [49:18] frame_number, rest zero
	output logic [1:0]  m_tuser,   // [1:0] result_kind
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import vpwr_pkg::*;

	thr_t        thr;
	logic        valid_s1, valid_s2;
	logic [31:0] edge_time_s1;
	result_t     result_s2;
	result_t     res;
	logic        emit;
	logic        out_free, fire;

	assign out_free = !valid_s2 || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || fire;

	vpwr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.thr       (thr)
	);

	vpwr_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.edge_time (edge_time_s1),
		.thr       (thr),
		.emit      (emit),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				valid_s2 <= fire && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			edge_time_s1 <= s_tdata;
		end
		if (fire && emit) begin
			result_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.kind;
	assign m_tdata  = {6'd0, result_s2.frame_number, result_s2.crc_ok,
		result_s2.frame_length, result_s2.byte_index, result_s2.byte_value};

endmodule
